FILE: sv/cct_pkg.sv
// package: transaction types, function codes and month length table for the calendar clock
`default_nettype none

package cct_pkg;

  // function codes carried in the func field
  localparam logic [1:0] FUNC_LOAD = 2'd0;
  localparam logic [1:0] FUNC_SEC  = 2'd1;
  localparam logic [1:0] FUNC_DAY  = 2'd2;

  // counter limits
  localparam logic [5:0] SEC_MAX   = 6'd59;
  localparam logic [5:0] MIN_MAX   = 6'd59;
  localparam logic [4:0] HOUR_MAX  = 5'd23;
  localparam logic [4:0] HOUR_NOON = 5'd12;
  localparam logic [3:0] MONTH_DEC = 4'd12;
  localparam logic [4:0] FEB_LEAP  = 5'd29;
  localparam logic [3:0] MONTH_FEB = 4'd2;

  // divisibility by 25: multiply by the inverse of 25 mod 2^16, compare
  localparam logic [15:0] INV25      = 16'd23593;
  localparam logic [15:0] DIV25_LIM  = 16'd2621;

  typedef struct packed {
    logic [1:0]  func;
    logic [5:0]  load_second;
    logic [5:0]  load_minute;
    logic [4:0]  load_hour;
    logic [4:0]  load_day;
    logic [3:0]  load_month;
    logic [15:0] load_year;
  } in_t;

  typedef struct packed {
    logic [5:0]  second_now;
    logic [5:0]  minute_now;
    logic [4:0]  hour_now;
    logic [4:0]  day_now;
    logic [3:0]  month_now;
    logic [15:0] year_now;
    logic        day_rolled;
    logic [3:0]  hour_twelve;
    logic        is_pm;
  } out_t;

  // days in a month for a common year; unused month codes have zero days
  function automatic logic [4:0] month_days(input logic [3:0] m);
    logic [4:0] len;
    case (m)
      4'd1:    len = 5'd31;
      4'd2:    len = 5'd28;
      4'd3:    len = 5'd31;
      4'd4:    len = 5'd30;
      4'd5:    len = 5'd31;
      4'd6:    len = 5'd30;
      4'd7:    len = 5'd31;
      4'd8:    len = 5'd31;
      4'd9:    len = 5'd30;
      4'd10:   len = 5'd31;
      4'd11:   len = 5'd30;
      4'd12:   len = 5'd31;
      default: len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

FILE: sv/calendar_clock_tick.sv
// top level: real-time clock and Gregorian calendar counter
`default_nettype none

// Calendar clock: each input transaction loads a date and time, advances one
// second or advances one day, and each gives exactly one result transaction
// with the full state after the step, a midnight flag and a 12-hour view.
// One transaction is taken every cycle while in_stall is low; it passes through
// the input register, then the result register, to give its result. The cycle is set
// by the second-to-date carry chain together with the leap year test, which
// uses one 16-bit constant multiply. The result register lets a new input be
// taken while the previous result waits. All counters reset to zero.
module calendar_clock_tick (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output      logic        in_stall,
  input  wire cct_pkg::in_t in_data,
  output      logic        out_valid,
  input  wire logic        out_stall,
  output      cct_pkg::out_t out_data
);

  // pipeline control and payload
  logic          s1_v_r;
  cct_pkg::in_t  s1_data_r;
  logic          out_v_r;
  cct_pkg::out_t out_data_r;
  logic          adv;

  // calendar state
  logic [5:0]  sec_r,   sec_nxt;
  logic [5:0]  min_r,   min_nxt;
  logic [4:0]  hour_r,  hour_nxt;
  logic [4:0]  day_r,   day_nxt;
  logic [3:0]  month_r, month_nxt;
  logic [15:0] year_r,  year_nxt;
  logic        rolled;

  // date step helpers
  logic        do_day;
  logic [15:0] y25_prod;
  logic        div25;
  logic        leap;
  logic [4:0]  mlen;
  logic [5:0]  day_inc;
  logic [3:0]  h12;
  logic        pm;

  // stage advance: the result register is free or being drained
  assign adv      = s1_v_r && (!out_v_r || !out_stall);
  assign in_stall = s1_v_r && !adv;

  // leap year: divisible by 4, and not by 100 unless by 400
  assign y25_prod = year_r * cct_pkg::INV25;
  assign div25    = (y25_prod <= cct_pkg::DIV25_LIM);
  assign leap     = (year_r[1:0] == 2'd0) && (!div25 || (year_r[3:0] == 4'd0));

  // month length with leap february
  always_comb begin
    mlen = cct_pkg::month_days(month_r);
    if (month_r == cct_pkg::MONTH_FEB && leap) begin
      mlen = cct_pkg::FEB_LEAP;
    end
  end

  assign day_inc = {1'b0, day_r} + 6'd1;

  // next state for the transaction in the input register
  always_comb begin
    sec_nxt   = sec_r;
    min_nxt   = min_r;
    hour_nxt  = hour_r;
    day_nxt   = day_r;
    month_nxt = month_r;
    year_nxt  = year_r;
    rolled    = 1'b0;
    do_day    = 1'b0;
    case (s1_data_r.func)
      cct_pkg::FUNC_LOAD: begin
        sec_nxt   = s1_data_r.load_second;
        min_nxt   = s1_data_r.load_minute;
        hour_nxt  = s1_data_r.load_hour;
        day_nxt   = s1_data_r.load_day;
        month_nxt = s1_data_r.load_month;
        year_nxt  = s1_data_r.load_year;
      end
      cct_pkg::FUNC_SEC: begin
        if (sec_r < cct_pkg::SEC_MAX) begin
          sec_nxt = sec_r + 6'd1;
        end else begin
          sec_nxt = 6'd0;
          if (min_r < cct_pkg::MIN_MAX) begin
            min_nxt = min_r + 6'd1;
          end else begin
            min_nxt = 6'd0;
            if (hour_r < cct_pkg::HOUR_MAX) begin
              hour_nxt = hour_r + 5'd1;
            end else begin
              hour_nxt = 5'd0;
              rolled   = 1'b1;
              do_day   = 1'b1;
            end
          end
        end
      end
      cct_pkg::FUNC_DAY: begin
        do_day = 1'b1;
      end
      default: begin
      end
    endcase
    // date advance
    if (do_day) begin
      if (day_inc > {1'b0, mlen}) begin
        day_nxt = 5'd1;
        if (month_r >= cct_pkg::MONTH_DEC) begin
          month_nxt = 4'd1;
          year_nxt  = year_r + 16'd1;
        end else begin
          month_nxt = month_r + 4'd1;
        end
      end else begin
        day_nxt = day_inc[4:0];
      end
    end
  end

  // 12-hour view of the new hour
  always_comb begin
    if (hour_nxt == 5'd0) begin
      h12 = 4'd12;
      pm  = 1'b0;
    end else if (hour_nxt < cct_pkg::HOUR_NOON) begin
      h12 = hour_nxt[3:0];
      pm  = 1'b0;
    end else if (hour_nxt == cct_pkg::HOUR_NOON) begin
      h12 = 4'd12;
      pm  = 1'b1;
    end else begin
      h12 = 4'(hour_nxt - cct_pkg::HOUR_NOON);
      pm  = 1'b1;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (!in_stall) begin
      s1_v_r <= in_valid;
    end
    if (!in_stall && in_valid) begin
      s1_data_r <= in_data;
    end
  end

  // calendar state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sec_r   <= '0;
      min_r   <= '0;
      hour_r  <= '0;
      day_r   <= '0;
      month_r <= '0;
      year_r  <= '0;
      out_v_r <= 1'b0;
    end else begin
      if (adv) begin
        sec_r   <= sec_nxt;
        min_r   <= min_nxt;
        hour_r  <= hour_nxt;
        day_r   <= day_nxt;
        month_r <= month_nxt;
        year_r  <= year_nxt;
        out_v_r <= 1'b1;
      end else if (!out_stall) begin
        out_v_r <= 1'b0;
      end
    end
    if (adv) begin
      out_data_r.second_now  <= sec_nxt;
      out_data_r.minute_now  <= min_nxt;
      out_data_r.hour_now    <= hour_nxt;
      out_data_r.day_now     <= day_nxt;
      out_data_r.month_now   <= month_nxt;
      out_data_r.year_now    <= year_nxt;
      out_data_r.day_rolled  <= rolled;
      out_data_r.hour_twelve <= h12;
      out_data_r.is_pm       <= pm;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_data_r;

  // checks
  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_v_r)
    else $error("input stalled with an empty input register");

  a_roll_at_midnight: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.day_rolled) |->
      (out_data.hour_now == 5'd0 && out_data.minute_now == 6'd0 &&
       out_data.second_now == 6'd0))
    else $error("day rollover without midnight time");

  a_roll_valid_date: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.day_rolled) |->
      (out_data.day_now != 5'd0 && out_data.month_now != 4'd0))
    else $error("day rollover left an unset date");

  a_pm_matches_hour: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.is_pm == (out_data.hour_now >= cct_pkg::HOUR_NOON)))
    else $error("pm flag disagrees with hour");

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// testbench for the calendar clock: scoreboard class, stimulus and result checking
`timescale 1ns / 100ps

module testbench;

  // func code that leaves the state alone
  localparam logic [1:0] FUNC_NOP = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  cct_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  cct_pkg::out_t out_data;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  calendar_clock_tick i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // tracks the calendar state and the readouts it should produce
  class calendar_scoreboard;
    logic [5:0]    cur_sec;
    logic [5:0]    cur_min;
    logic [4:0]    cur_hour;
    logic [4:0]    cur_day;
    logic [3:0]    cur_month;
    logic [15:0]   cur_year;
    logic [4:0]    month_len [16];
    cct_pkg::out_t expected_readouts[$];
    int            mismatches;

    function new();
      month_len = '{5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
                    5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd0, 5'd0, 5'd0};
      cur_sec = '0;
      cur_min = '0;
      cur_hour = '0;
      cur_day = '0;
      cur_month = '0;
      cur_year = '0;
      mismatches = 0;
    endfunction

    // gregorian rule: every 4th year, centuries only when divisible by 400
    function bit is_leap(logic [15:0] y);
      if (y % 4 != 0) return 1'b0;
      if (y % 400 == 0) return 1'b1;
      return (y % 100 != 0);
    endfunction

    // one calendar day forward; unused months have no days
    function void step_date();
      logic [4:0] len;
      logic [5:0] day_next;
      len = month_len[cur_month];
      if (cur_month == cct_pkg::MONTH_FEB && is_leap(cur_year)) len = cct_pkg::FEB_LEAP;
      day_next = {1'b0, cur_day} + 6'd1;
      if (day_next > {1'b0, len}) begin
        cur_day = 5'd1;
        if (cur_month >= cct_pkg::MONTH_DEC) begin
          cur_month = 4'd1;
          cur_year = cur_year + 16'd1;
        end else begin
          cur_month = cur_month + 4'd1;
        end
      end else begin
        cur_day = day_next[4:0];
      end
    endfunction

    // one second forward, returns 1 when midnight is passed
    function bit step_second();
      if (cur_sec < cct_pkg::SEC_MAX) begin
        cur_sec = cur_sec + 6'd1;
        return 1'b0;
      end
      cur_sec = '0;
      if (cur_min < cct_pkg::MIN_MAX) begin
        cur_min = cur_min + 6'd1;
        return 1'b0;
      end
      cur_min = '0;
      if (cur_hour < cct_pkg::HOUR_MAX) begin
        cur_hour = cur_hour + 5'd1;
        return 1'b0;
      end
      cur_hour = '0;
      return 1'b1;
    endfunction

    // apply an accepted input transaction and queue the readout it causes
    function void record_input(cct_pkg::in_t t);
      cct_pkg::out_t r;
      bit rolled;
      logic [4:0] past_noon;
      rolled = 1'b0;
      case (t.func)
        cct_pkg::FUNC_LOAD: begin
          cur_sec = t.load_second;
          cur_min = t.load_minute;
          cur_hour = t.load_hour;
          cur_day = t.load_day;
          cur_month = t.load_month;
          cur_year = t.load_year;
        end
        cct_pkg::FUNC_SEC: begin
          rolled = step_second();
          if (rolled) step_date();
        end
        cct_pkg::FUNC_DAY: step_date();
        default: ;
      endcase
      r.second_now = cur_sec;
      r.minute_now = cur_min;
      r.hour_now = cur_hour;
      r.day_now = cur_day;
      r.month_now = cur_month;
      r.year_now = cur_year;
      r.day_rolled = rolled;
      // 12-hour view, midnight shown as 12
      past_noon = cur_hour - cct_pkg::HOUR_NOON;
      if (cur_hour == 5'd0) begin
        r.hour_twelve = 4'd12;
        r.is_pm = 1'b0;
      end else if (cur_hour < cct_pkg::HOUR_NOON) begin
        r.hour_twelve = cur_hour[3:0];
        r.is_pm = 1'b0;
      end else if (cur_hour == cct_pkg::HOUR_NOON) begin
        r.hour_twelve = 4'd12;
        r.is_pm = 1'b1;
      end else begin
        r.hour_twelve = past_noon[3:0];
        r.is_pm = 1'b1;
      end
      expected_readouts.push_back(r);
    endfunction

    function string fmt(cct_pkg::out_t r);
      return $sformatf("%0d:%0d:%0d %0d/%0d/%0d rolled=%0d h12=%0d pm=%0d",
                       r.hour_now, r.minute_now, r.second_now, r.month_now,
                       r.day_now, r.year_now, r.day_rolled, r.hour_twelve, r.is_pm);
    endfunction

    // compare a result transaction with the oldest queued readout
    function void check_readout(cct_pkg::out_t got);
      cct_pkg::out_t want;
      if (expected_readouts.size() == 0) begin
        if (mismatches < 10) $display("unexpected result: %s", fmt(got));
        mismatches++;
        return;
      end
      want = expected_readouts.pop_front();
      if (got.second_now !== want.second_now || got.minute_now !== want.minute_now ||
          got.hour_now !== want.hour_now || got.day_now !== want.day_now ||
          got.month_now !== want.month_now || got.year_now !== want.year_now ||
          got.day_rolled !== want.day_rolled || got.hour_twelve !== want.hour_twelve ||
          got.is_pm !== want.is_pm) begin
        if (mismatches < 10) begin
          $display("mismatch: expected %s", fmt(want));
          $display("          actual   %s", fmt(got));
        end
        mismatches++;
      end
    endfunction
  endclass

  calendar_scoreboard sb;

  // clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // receiver back-pressure
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // result sampling
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_readout(out_data);
  end

  function automatic cct_pkg::in_t random_payload();
    logic [63:0] r;
    cct_pkg::in_t t;
    r = {$urandom(), $urandom()};
    t = r[$bits(cct_pkg::in_t)-1:0];
    return t;
  endfunction

  function automatic cct_pkg::in_t make_load(logic [5:0] s, logic [5:0] m, logic [4:0] h,
                                             logic [4:0] d, logic [3:0] mo,
                                             logic [15:0] y);
    cct_pkg::in_t t;
    t.func = cct_pkg::FUNC_LOAD;
    t.load_second = s;
    t.load_minute = m;
    t.load_hour = h;
    t.load_day = d;
    t.load_month = mo;
    t.load_year = y;
    return t;
  endfunction

  // non-load transaction, payload bits random since they are ignored
  function automatic cct_pkg::in_t tick_op(logic [1:0] code);
    cct_pkg::in_t t;
    t = random_payload();
    t.func = code;
    return t;
  endfunction

  // load close to a carry: end of minute, hour, day, month or a special year
  function automatic cct_pkg::in_t boundary_load();
    cct_pkg::in_t t;
    t.func = cct_pkg::FUNC_LOAD;
    t.load_second = $urandom_range(1) ? 6'(59 - $urandom_range(3)) : 6'($urandom_range(59));
    t.load_minute = $urandom_range(1) ? 6'd59 : 6'($urandom_range(59));
    t.load_hour = $urandom_range(1) ? 5'd23 : 5'($urandom_range(23));
    t.load_month = 4'($urandom_range(12));
    case ($urandom_range(2))
      0: t.load_day = 5'($urandom_range(31));
      1: t.load_day = 5'($urandom_range(31, 27));
      default: t.load_day = 5'($urandom_range(29, 28));
    endcase
    case ($urandom_range(6))
      0: t.load_year = 16'($urandom_range(65535));
      1: t.load_year = 16'(4 * $urandom_range(16383));
      2: t.load_year = 16'(100 * $urandom_range(655));
      3: t.load_year = 16'(400 * $urandom_range(163));
      4: t.load_year = 16'd65535;
      5: t.load_year = 16'(65535 - $urandom_range(3));
      default: t.load_year = 16'd0;
    endcase
    return t;
  endfunction

  function automatic cct_pkg::in_t random_tick();
    int r;
    r = $urandom_range(99);
    if (r < 65) return tick_op(cct_pkg::FUNC_SEC);
    if (r < 92) return tick_op(cct_pkg::FUNC_DAY);
    return tick_op(FUNC_NOP);
  endfunction

  // drive one input transaction, called and returning at a falling edge
  task automatic send_item(input cct_pkg::in_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.record_input(item);
    @(negedge clk);
  endtask

  // mostly a load near a carry followed by a run of ticks, some noise
  task automatic run_random(input int count);
    int left;
    int ticks;
    left = count;
    while (left > 0) begin
      if ($urandom_range(9) == 0) begin
        send_item(random_payload());
        left--;
      end else begin
        send_item(boundary_load());
        left--;
        ticks = $urandom_range(40, 5);
        while (ticks > 0 && left > 0) begin
          send_item(random_tick());
          ticks--;
          left--;
        end
      end
    end
  endtask

  // run limit
  initial begin
    #400000;
    $display("FAIL");
    $finish;
  end

  // main sequence
  initial begin
    sb = new();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: from reset state, month 0 and unused func
    send_item(tick_op(cct_pkg::FUNC_SEC));
    send_item(tick_op(cct_pkg::FUNC_DAY));
    send_item(tick_op(FUNC_NOP));
    // year wrap through a second tick at new year's eve
    send_item(make_load(6'd59, 6'd59, 5'd23, 5'd31, 4'd12, 16'd65535));
    send_item(tick_op(cct_pkg::FUNC_SEC));
    // leap century, common century, ordinary leap year
    send_item(make_load(6'd59, 6'd59, 5'd23, 5'd28, 4'd2, 16'd2000));
    send_item(tick_op(cct_pkg::FUNC_SEC));
    send_item(tick_op(cct_pkg::FUNC_DAY));
    send_item(make_load(6'd0, 6'd0, 5'd12, 5'd28, 4'd2, 16'd1900));
    send_item(tick_op(cct_pkg::FUNC_DAY));
    send_item(make_load(6'd0, 6'd0, 5'd13, 5'd28, 4'd2, 16'd2024));
    send_item(tick_op(cct_pkg::FUNC_DAY));
    send_item(tick_op(cct_pkg::FUNC_DAY));
    // every field at its all-ones value, then a tick out of it
    send_item(make_load(6'd63, 6'd63, 5'd31, 5'd31, 4'd15, 16'd65535));
    send_item(tick_op(cct_pkg::FUNC_SEC));
    // hour above 23 and day beyond the month length
    send_item(make_load(6'd59, 6'd59, 5'd25, 5'd31, 4'd4, 16'd1999));
    send_item(tick_op(cct_pkg::FUNC_SEC));
    // all zeros, then a date step out of month 0
    send_item(make_load(6'd0, 6'd0, 5'd0, 5'd0, 4'd0, 16'd0));
    send_item(tick_op(cct_pkg::FUNC_DAY));
    // carry into noon
    send_item(make_load(6'd59, 6'd59, 5'd11, 5'd15, 4'd6, 16'd2023));
    send_item(tick_op(cct_pkg::FUNC_SEC));
    // seconds above 59 carry like 59
    send_item(make_load(6'd61, 6'd59, 5'd5, 5'd10, 4'd7, 16'd1));
    send_item(tick_op(cct_pkg::FUNC_SEC));

    // random phases with different idle and stall rates
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 46;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 46;
        end
        default: begin
          send_idle_pct = 27;
          recv_stall_pct = 27;
        end
      endcase
      run_random(413);
    end
    in_valid <= 1'b0;

    // drain and let any stray result show up
    while (sb.expected_readouts.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

FILE: files.f
sv/cct_pkg.sv
sv/calendar_clock_tick.sv
tb/testbench.sv
